FILE: hdl/sirt_pkg.sv
// Shared types, constants and helpers for the signed integer to radix text converter.
`timescale 1ns / 1ps

package sirt_pkg;

  // Input value and character widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;

  // Alphabet register file: eight 64-bit words of packed byte slots.
  localparam int unsigned WORD_COUNT = 8;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned ALPHABET_SLOTS_DEF = 64;

  // Reset alphabet spells "0123456789", which gives radix ten.
  localparam logic [WORD_W-1:0] WORD0_RESET = 64'd3978425819141910832;
  localparam logic [WORD_W-1:0] WORD1_RESET = 64'd14648;

  // Digit stack: a 32-bit magnitude has at most 32 digits (radix two).
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned DIG_IDX_W = 5;
  localparam int unsigned DIG_CNT_W = 6;
  localparam int unsigned BIT_CNT_W = 5;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_SCAN,
    ST_DUP,
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } conv_state_e;

  // True for A-Z, a-z and 0-9.
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
           ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ||
           ((c >= CHAR_ZERO) && (c <= CHAR_NINE));
  endfunction

endpackage

FILE: hdl/signed_integer_to_radix_text.sv
// Top level: converts a signed 32-bit value to text in a configurable digit alphabet.
`timescale 1ns / 1ps

// A value is accepted when start_i is high while busy_o is low. Its characters
// leave on text_char_o, one per cycle while result_valid_o is high, with
// last_char_o marking the final one; the receiver cannot stall them. Digits
// come from one shared restoring divider that retires one quotient bit per
// cycle. All digits of an item are divided out first; then the minus sign, if
// any, and the digits are sent, most significant first. busy_o stays high
// until the item is done, and its last character is on text_char_o in the
// first cycle with busy_o low. An item arriving while the alphabet is invalid
// is taken and gives no characters. After reset and after every write to an
// alphabet word the block checks the alphabet (length scan, character class,
// then a pairwise duplicate check, one compare a cycle) and holds busy_o high
// meanwhile. Writes to the alphabet are always taken and belong in idle time.
module signed_integer_to_radix_text #(
  parameter int unsigned ALPHABET_SLOTS = sirt_pkg::ALPHABET_SLOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [sirt_pkg::DATA_W-1:0]   number_i,
  output logic                                 result_valid_o,
  output logic        [sirt_pkg::CHAR_W-1:0]   text_char_o,
  output logic                                 last_char_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [sirt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [sirt_pkg::WORD_W-1:0]   cfg_data_i
);

  localparam int unsigned SlotW = (ALPHABET_SLOTS > 2) ? $clog2(ALPHABET_SLOTS) : 1;
  localparam int unsigned LenW = $clog2(ALPHABET_SLOTS + 1);
  localparam int unsigned DataW = sirt_pkg::DATA_W;
  localparam int unsigned CharW = sirt_pkg::CHAR_W;

  sirt_pkg::conv_state_e state_q, state_d;

  logic [sirt_pkg::WORD_W-1:0] alpha_q [sirt_pkg::WORD_COUNT];
  logic [sirt_pkg::WORD_COUNT*sirt_pkg::WORD_W-1:0] alpha_flat;
  logic cfg_we;

  logic [LenW-1:0] pos_i_q, pos_i_d;
  logic [SlotW-1:0] pos_j_q, pos_j_d;
  logic [LenW-1:0] radix_q, radix_d;
  logic alpha_ok_q, alpha_ok_d;

  logic [sirt_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [SlotW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic neg_q, neg_d;
  logic [sirt_pkg::DIG_CNT_W-1:0] nd_q, nd_d;

  logic result_valid_q, result_valid_d;
  logic [CharW-1:0] text_char_q, text_char_d;
  logic last_char_q, last_char_d;

  logic [SlotW-1:0] digit_mem [sirt_pkg::MAX_DIGITS];
  logic dig_we;
  logic [sirt_pkg::DIG_IDX_W-1:0] dig_rd_idx;
  logic [SlotW-1:0] dig_rd;

  logic [SlotW-1:0] addr_a;
  logic [CharW-1:0] char_a, char_b;

  logic [DataW-1:0] raw;
  logic [DataW-1:0] mag_in;
  logic [SlotW:0] trial, trial_diff, radix_ext;
  logic trial_ge;
  logic [SlotW-1:0] rem_new;
  logic [DataW-1:0] quo_new;
  logic [sirt_pkg::DIG_CNT_W-1:0] nd_m1;

  // Configuration writes land directly; out-of-range indexes are dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o &&
                  (cfg_index_i < sirt_pkg::CFG_IDX_W'(sirt_pkg::WORD_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sirt_pkg::WORD_COUNT; k++) begin
        if (k == 0) begin
          alpha_q[k] <= sirt_pkg::WORD0_RESET;
        end else if (k == 1) begin
          alpha_q[k] <= sirt_pkg::WORD1_RESET;
        end else begin
          alpha_q[k] <= '0;
        end
      end
    end else if (cfg_we) begin
      alpha_q[cfg_index_i[$clog2(sirt_pkg::WORD_COUNT)-1:0]] <= cfg_data_i;
    end
  end

  // Slot s of the alphabet is byte s of the words laid end to end.
  always_comb begin
    for (int k = 0; k < sirt_pkg::WORD_COUNT; k++) begin
      alpha_flat[k*sirt_pkg::WORD_W +: sirt_pkg::WORD_W] = alpha_q[k];
    end
  end

  assign char_a = alpha_flat[{addr_a, 3'b000} +: CharW];
  assign char_b = alpha_flat[{pos_j_q, 3'b000} +: CharW];

  // Digit stack: digits are pushed least significant first and popped in reverse.
  assign nd_m1 = nd_q - sirt_pkg::DIG_CNT_W'(1);
  assign dig_rd_idx = nd_m1[sirt_pkg::DIG_IDX_W-1:0];
  assign dig_rd = digit_mem[dig_rd_idx];

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digit_mem[nd_q[sirt_pkg::DIG_IDX_W-1:0]] <= rem_new;
    end
  end

  // Magnitude of the input; the most negative value wraps to 2^31 as unsigned.
  assign raw = number_i;
  assign mag_in = raw[DataW-1] ? (~raw + DataW'(1)) : raw;

  // Shared divider step: one restoring quotient bit per cycle.
  assign trial = {rem_q, quo_q[DataW-1]};
  assign radix_ext = (SlotW + 1)'(radix_q);
  assign trial_ge = (trial >= radix_ext);
  assign trial_diff = trial - radix_ext;
  assign rem_new = trial_ge ? trial_diff[SlotW-1:0] : trial[SlotW-1:0];
  assign quo_new = {quo_q[DataW-2:0], trial_ge};

  // Sequencer: alphabet check, division per digit, then character output.
  always_comb begin
    state_d = state_q;
    pos_i_d = pos_i_q;
    pos_j_d = pos_j_q;
    radix_d = radix_q;
    alpha_ok_d = alpha_ok_q;
    bit_cnt_d = bit_cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    nd_d = nd_q;
    result_valid_d = 1'b0;
    text_char_d = text_char_q;
    last_char_d = last_char_q;
    dig_we = 1'b0;
    addr_a = pos_i_q[SlotW-1:0];

    case (state_q)
      sirt_pkg::ST_SCAN: begin
        if ((pos_i_q == LenW'(ALPHABET_SLOTS)) || (char_a == sirt_pkg::CHAR_NUL)) begin
          radix_d = pos_i_q;
          if (pos_i_q <= LenW'(1)) begin
            alpha_ok_d = 1'b0;
            state_d = sirt_pkg::ST_IDLE;
          end else begin
            pos_i_d = LenW'(1);
            pos_j_d = '0;
            state_d = sirt_pkg::ST_DUP;
          end
        end else if (!sirt_pkg::is_alnum(char_a)) begin
          alpha_ok_d = 1'b0;
          state_d = sirt_pkg::ST_IDLE;
        end else begin
          pos_i_d = pos_i_q + LenW'(1);
        end
      end

      sirt_pkg::ST_DUP: begin
        if (char_a == char_b) begin
          alpha_ok_d = 1'b0;
          state_d = sirt_pkg::ST_IDLE;
        end else if ((LenW'(pos_j_q) + LenW'(1)) == pos_i_q) begin
          if ((pos_i_q + LenW'(1)) == radix_q) begin
            alpha_ok_d = 1'b1;
            state_d = sirt_pkg::ST_IDLE;
          end else begin
            pos_i_d = pos_i_q + LenW'(1);
            pos_j_d = '0;
          end
        end else begin
          pos_j_d = pos_j_q + SlotW'(1);
        end
      end

      sirt_pkg::ST_IDLE: begin
        if (start_i && alpha_ok_q) begin
          neg_d = raw[DataW-1];
          quo_d = mag_in;
          rem_d = '0;
          bit_cnt_d = '0;
          nd_d = '0;
          state_d = sirt_pkg::ST_DIV;
        end
      end

      sirt_pkg::ST_DIV: begin
        quo_d = quo_new;
        rem_d = rem_new;
        bit_cnt_d = bit_cnt_q + sirt_pkg::BIT_CNT_W'(1);
        if (bit_cnt_q == sirt_pkg::BIT_CNT_W'(DataW - 1)) begin
          // Remainder is the next digit; the quotient feeds the next division.
          dig_we = 1'b1;
          nd_d = nd_q + sirt_pkg::DIG_CNT_W'(1);
          rem_d = '0;
          if (quo_new == '0) begin
            state_d = neg_q ? sirt_pkg::ST_SIGN : sirt_pkg::ST_OUT;
          end
        end
      end

      sirt_pkg::ST_SIGN: begin
        result_valid_d = 1'b1;
        text_char_d = sirt_pkg::CHAR_MINUS;
        last_char_d = 1'b0;
        state_d = sirt_pkg::ST_OUT;
      end

      sirt_pkg::ST_OUT: begin
        addr_a = dig_rd;
        result_valid_d = 1'b1;
        text_char_d = char_a;
        last_char_d = (nd_q == sirt_pkg::DIG_CNT_W'(1));
        nd_d = nd_m1;
        if (nd_q == sirt_pkg::DIG_CNT_W'(1)) begin
          state_d = sirt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sirt_pkg::ST_IDLE;
      end
    endcase

    // A new alphabet word restarts the check.
    if (cfg_we) begin
      pos_i_d = '0;
      state_d = sirt_pkg::ST_SCAN;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sirt_pkg::ST_SCAN;
      pos_i_q <= '0;
      alpha_ok_q <= 1'b0;
      result_valid_q <= 1'b0;
      bit_cnt_q <= '0;
      nd_q <= '0;
    end else begin
      state_q <= state_d;
      pos_i_q <= pos_i_d;
      alpha_ok_q <= alpha_ok_d;
      result_valid_q <= result_valid_d;
      bit_cnt_q <= bit_cnt_d;
      nd_q <= nd_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pos_j_q <= pos_j_d;
    radix_q <= radix_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    text_char_q <= text_char_d;
    last_char_q <= last_char_d;
  end

  assign busy_o = (state_q != sirt_pkg::ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign text_char_o = text_char_q;
  assign last_char_o = last_char_q;

endmodule
